[rtl/vsd_pkg.sv]
package vsd_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int VALUE_BITS      = 64;
    localparam int COUNT_BITS      = 4;
    localparam int POS_BITS        = 7;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [POS_BITS-1:0]   POS_MAX   = 7'd127;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 4'd15;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       signed_mode;
    } vsd_in_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [COUNT_BITS-1:0] byte_count;
        logic                  overflow;
    } vsd_out_t;

    // one classified byte, passed from front to back
    typedef struct packed {
        logic [6:0] payload;
        logic       group_six;
        logic       negative;
        logic       first;
        logic       last;
    } vsd_entry_t;

endpackage

[rtl/vsd_front.sv]
module vsd_front
    import vsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  vsd_in_t    s_data,
    output logic       push,
    output vsd_entry_t push_entry,
    input  logic       queue_full
);

    logic in_progress_reg;
    logic in_progress_next;
    logic signed_first;

    assign s_ready = !queue_full;
    assign push    = s_valid && s_ready;

    // sign bit only exists on the first byte of a signed number
    assign signed_first = !in_progress_reg && s_data.signed_mode;

    always_comb begin
        push_entry.first     = !in_progress_reg;
        push_entry.last      = !s_data.data_byte[7];
        push_entry.group_six = signed_first;
        push_entry.negative  = signed_first && s_data.data_byte[6];
        push_entry.payload   = signed_first ? {1'b0, s_data.data_byte[5:0]}
                                            : s_data.data_byte[6:0];
    end

    always_comb begin
        in_progress_next = in_progress_reg;
        if (push) begin
            in_progress_next = s_data.data_byte[7];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_progress_reg <= 1'b0;
        end else begin
            in_progress_reg <= in_progress_next;
        end
    end

endmodule

[rtl/vsd_queue.sv]
module vsd_queue
    import vsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  vsd_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output vsd_entry_t head_entry
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    vsd_entry_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[rtl/vsd_back.sv]
module vsd_back
    import vsd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  vsd_entry_t head_entry,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output vsd_out_t   m_data
);

    localparam logic [POS_BITS-1:0] W_POS = POS_BITS'(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] acc_reg, acc_next, acc_base, acc_fin;
    logic [POS_BITS-1:0]    pos_reg, pos_next, pos_base;
    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next, cnt_base;
    logic                   ovf_reg, ovf_next, ovf_base;
    logic                   neg_reg, neg_next;
    logic [VALUE_WIDTH+6:0] shifted;
    logic [POS_BITS:0]      pos_sum;
    logic                   out_valid_reg, out_valid_next;
    vsd_out_t               out_data_reg, out_data_next;

    assign pop     = head_valid && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        // a new number starts from a clean state
        acc_base = head_entry.first ? '0 : acc_reg;
        pos_base = head_entry.first ? '0 : pos_reg;
        cnt_base = head_entry.first ? '0 : cnt_reg;
        ovf_base = head_entry.first ? 1'b0 : ovf_reg;
        neg_next = head_entry.first ? head_entry.negative : neg_reg;

        shifted = {{VALUE_WIDTH{1'b0}}, head_entry.payload} << pos_base;

        // groups never overlap, so or-ing is the same as adding
        acc_next = acc_base | shifted[VALUE_WIDTH-1:0];
        if (pos_base < W_POS) begin
            ovf_next = ovf_base || (|shifted[VALUE_WIDTH+6:VALUE_WIDTH]);
        end else begin
            ovf_next = ovf_base || (|head_entry.payload);
        end

        pos_sum  = {1'b0, pos_base} + (head_entry.group_six ? 8'd6 : 8'd7);
        pos_next = pos_sum[POS_BITS] ? POS_MAX : pos_sum[POS_BITS-1:0];
        cnt_next = (cnt_base == COUNT_MAX) ? COUNT_MAX : cnt_base + 1'b1;

        acc_fin = neg_next ? ('0 - acc_next) : acc_next;

        out_data_next.value      = VALUE_BITS'(acc_fin);
        out_data_next.byte_count = cnt_next;
        out_data_next.overflow   = ovf_next;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (pop && head_entry.last) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            acc_reg <= acc_next;
            pos_reg <= pos_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            neg_reg <= neg_next;
        end
        if (pop && head_entry.last) begin
            out_data_reg <= out_data_next;
        end
    end

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head_entry.last) |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten while still pending");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg.byte_count != '0))
        else $error("result with zero byte count");

    a_last_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head_entry.last) |=> out_valid_reg)
        else $error("final byte did not produce a result");

endmodule

[rtl/varint_stream_decoder.sv]
// varint_stream_decoder
//
// decodes little-endian 7-bit-group variable-length integers, one byte per
// transfer on the s_ channel (data_byte, signed_mode). bit 7 of a byte set
// means more bytes follow. signed_mode is taken from the first byte of each
// number; in signed mode bit 6 of that byte is the sign.
//
// one result transfer on the m_ channel per final byte: value, byte_count
// (saturating at 15) and a sticky overflow flag for payload bits that fell
// at or above VALUE_WIDTH.
//
// throughput: one byte per cycle while the output register is free, limited
// by the single accumulate step in the back end. latency: the final byte is
// registered in the queue, and the back end loads the result register that
// drives m_valid as it pops the byte; more if older bytes still wait. when
// the receiver stalls, the result waits in the output register while the
// two-entry queue keeps taking bytes; s_ready drops once it is full.
// reset (aresetn low, synchronous) empties the queue and the output
// register and makes the next byte the first of a new number.
module varint_stream_decoder
    import vsd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  vsd_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output vsd_out_t m_data
);

    // classified byte from the front end
    logic       push;
    vsd_entry_t push_entry;
    logic       queue_full;

    // queue head toward the back end
    logic       pop;
    logic       head_valid;
    vsd_entry_t head_entry;

    // front: tracks number boundaries, splits sign and payload
    vsd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push       (push),
        .push_entry (push_entry),
        .queue_full (queue_full)
    );

    // short queue so front and back stall independently
    vsd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // back: accumulates groups, negates and registers the result
    vsd_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

[verif/varint_checker.sv]
`timescale 1ns / 100ps
module varint_checker
    import vsd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  vsd_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  vsd_out_t m_data,
    output int       error_count,
    output int       numbers_pending
);

    localparam logic [VALUE_BITS-1:0] VALUE_MASK = (VALUE_WIDTH >= VALUE_BITS) ?
        {VALUE_BITS{1'b1}} : ((64'd1 << VALUE_WIDTH) - 64'd1);

    // decoder state as this side sees it
    logic [VALUE_BITS-1:0] magnitude;
    int unsigned           shift_pos;
    int unsigned           byte_tally;
    logic                  mid_number;
    logic                  sign_neg;
    logic                  mode_latched;
    logic                  dropped_bits;
    int                    mismatches;
    vsd_out_t              decoded_numbers[$];

    task automatic decode_byte(input vsd_in_t item);
        logic [VALUE_BITS-1:0] payload;
        int unsigned           group_bits;
        int unsigned           room;
        vsd_out_t              number;
        if (!mid_number) begin
            mode_latched = item.signed_mode;
            magnitude    = '0;
            shift_pos    = 0;
            sign_neg     = 1'b0;
            dropped_bits = 1'b0;
            byte_tally   = 0;
        end
        // sign-magnitude numbers spend bit 6 of their first byte on the sign
        if (shift_pos == 0 && byte_tally == 0 && mode_latched) begin
            sign_neg   = item.data_byte[6];
            payload    = VALUE_BITS'(item.data_byte[5:0]);
            group_bits = 6;
        end else begin
            payload    = VALUE_BITS'(item.data_byte[6:0]);
            group_bits = 7;
        end
        if (shift_pos < VALUE_WIDTH) begin
            room = VALUE_WIDTH - shift_pos;
            if (room < 7 && (payload >> room) != '0)
                dropped_bits = 1'b1;
            magnitude = (magnitude + (payload << shift_pos)) & VALUE_MASK;
        end else if (payload != '0) begin
            dropped_bits = 1'b1;
        end
        shift_pos = shift_pos + group_bits;
        if (shift_pos > POS_MAX)
            shift_pos = 32'(POS_MAX);
        if (byte_tally < COUNT_MAX)
            byte_tally++;
        mid_number = item.data_byte[7];
        if (!item.data_byte[7]) begin
            number.value      = (sign_neg ? (VALUE_BITS'(0) - magnitude) : magnitude)
                                & VALUE_MASK;
            number.byte_count = COUNT_BITS'(byte_tally);
            number.overflow   = dropped_bits;
            decoded_numbers.insert(decoded_numbers.size(), number);
        end
    endtask

    task automatic check_number(input vsd_out_t got);
        vsd_out_t want;
        if (decoded_numbers.size() == 0) begin
            $display("%0t: unexpected result, expected none, got value %h count %0d ovf %0b",
                     $time, got.value, got.byte_count, got.overflow);
            mismatches++;
        end else begin
            want = decoded_numbers.pop_front();
            if (got.value !== want.value) begin
                $display("%0t: value mismatch, expected %h, got %h",
                         $time, want.value, got.value);
                mismatches++;
            end
            if (got.byte_count !== want.byte_count) begin
                $display("%0t: byte_count mismatch, expected %0d, got %0d",
                         $time, want.byte_count, got.byte_count);
                mismatches++;
            end
            if (got.overflow !== want.overflow) begin
                $display("%0t: overflow mismatch, expected %0b, got %0b",
                         $time, want.overflow, got.overflow);
                mismatches++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            mid_number   = 1'b0;
            magnitude    = '0;
            shift_pos    = 0;
            byte_tally   = 0;
            sign_neg     = 1'b0;
            mode_latched = 1'b0;
            dropped_bits = 1'b0;
            decoded_numbers.delete();
        end else begin
            if (s_valid && s_ready)
                decode_byte(s_data);
            if (m_valid && m_ready)
                check_number(m_data);
        end
        error_count     <= mismatches;
        numbers_pending <= decoded_numbers.size();
    end

endmodule

[verif/tb_varint_stream_decoder.sv]
`timescale 1ns / 100ps
module tb_varint_stream_decoder
    import vsd_pkg::*;
();

    localparam int RANDOM_BYTES = 850;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 48;
    localparam int TAIL_CYCLES  = 8;
    localparam int HOLD_AT      = 250;
    localparam int PAUSE_AT     = 550;

    // receiver behavior for one stretch of cycles
    typedef enum int {
        RX_OPEN,
        RX_MOSTLY,
        RX_SPARSE,
        RX_TOGGLE
    } rx_style_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    vsd_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    vsd_out_t m_data;

    int        error_count;
    int        numbers_pending;
    int        cycle_count;
    int        bytes_sent;
    int        burst_left;
    int        random_start;
    int        length_pick;
    bit        hold_request;
    bit        hold_served;
    bit        hold_done;
    bit        pause_done;
    rx_style_t rx_style;
    int        rx_stretch;
    int        held_cycles;

    varint_stream_decoder u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    varint_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .error_count     (error_count),
        .numbers_pending (numbers_pending)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // hard stop in case the pipeline wedges
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // offer one byte and hold it until the transfer; called at a rising edge.
    // after the transfer either keep valid up for the rest of the burst or
    // drop it for a random gap, unless the next burst follows back to back
    task automatic push_byte(input logic [7:0] code, input logic mode);
        int gap;
        s_valid          <= 1'b1;
        s_data.data_byte   <= code;
        s_data.signed_mode <= mode;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            // some bursts follow each other back to back
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // one well-formed number: continuation bit on all but the last byte.
    // the mode line is only meaningful on the first byte, so later bytes
    // carry random junk there
    task automatic send_number(input int unsigned len, input logic mode);
        logic [6:0] group;
        bit         quiet_tail;
        int         pick;
        quiet_tail = ($urandom_range(0, 1) == 1);
        for (int unsigned i = 0; i < len; i++) begin
            pick = $urandom_range(0, 5);
            if (pick == 0)
                group = 7'h7f;
            else if (pick == 1)
                group = 7'h00;
            else
                group = 7'($urandom);
            // keep groups past the value width empty so long numbers also end
            // without overflow
            if (quiet_tail && i >= 9)
                group = (i == 9) ? (group & 7'h01) : 7'h00;
            push_byte({(i != len - 1), group}, (i == 0) ? mode : 1'($urandom));
        end
    endtask

    // stop offering and let every outstanding result drain out
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (numbers_pending != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // receiver: random stall styles in stretches, plus one long hold-off
    // on request so the input side backs up
    initial begin
        m_ready     <= 1'b0;
        rx_style    = RX_OPEN;
        rx_stretch  = 0;
        held_cycles = 0;
        hold_served = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_served) begin
                m_ready <= 1'b0;
                held_cycles = 0;
                while (held_cycles < LONG_HOLD) begin
                    @(posedge aclk);
                    held_cycles++;
                end
                hold_served = 1'b1;
            end
            if (rx_stretch == 0) begin
                rx_style   = rx_style_t'($urandom_range(0, 3));
                rx_stretch = $urandom_range(10, 80);
            end
            rx_stretch--;
            case (rx_style)
                RX_OPEN:   m_ready <= 1'b1;
                RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= ~m_ready;
            endcase
        end
    end

    initial begin
        bytes_sent   = 0;
        burst_left   = 0;
        hold_request = 1'b0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-byte extremes: unsigned 0 and 127, signed -63, negative
        // zero and +63
        push_byte(8'h00, 1'b0);
        push_byte(8'h7f, 1'b0);
        push_byte(8'h7f, 1'b1);
        push_byte(8'h40, 1'b1);
        push_byte(8'h3f, 1'b1);
        // all ones at full width, mode line toggling mid-number
        for (int i = 0; i < 9; i++)
            push_byte(8'hff, i[0]);
        push_byte(8'h01, 1'b1);
        // signed, top group spills past the width: bit 63 lands, bit 64 is
        // dropped with overflow, and negating 2^63 wraps onto itself
        push_byte(8'hc0, 1'b1);
        for (int i = 0; i < 8; i++)
            push_byte(8'h80, 1'b0);
        push_byte(8'h06, 1'b0);
        wait_for_results();

        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            if (!hold_done && bytes_sent - random_start >= HOLD_AT) begin
                // receiver goes quiet while the sender keeps pushing
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!pause_done && bytes_sent - random_start >= PAUSE_AT) begin
                wait_for_results();
                pause_done = 1'b1;
            end
            length_pick = $urandom_range(0, 99);
            if (length_pick < 8) begin
                // raw noise: random bytes with random continuation bits
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom), 1'($urandom));
            end else if (length_pick < 55) begin
                send_number($urandom_range(1, 2), 1'($urandom));
            end else if (length_pick < 80) begin
                send_number($urandom_range(3, 9), 1'($urandom));
            end else if (length_pick < 90) begin
                send_number(10, 1'($urandom));
            end else if (length_pick < 96) begin
                // past the width, and for the longer ones past the count saturation
                send_number($urandom_range(11, 18), 1'($urandom));
            end else begin
                // long enough for the bit position to pin at its maximum
                send_number($urandom_range(19, 24), 1'($urandom));
            end
        end

        wait_for_results();
        if (error_count == 0 && numbers_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/vsd_pkg.sv
rtl/vsd_front.sv
rtl/vsd_queue.sv
rtl/vsd_back.sv
rtl/varint_stream_decoder.sv
verif/varint_checker.sv
verif/tb_varint_stream_decoder.sv
